// ----- rtl/qrs_pkg.sv -----
// Shared constants for the quadratic root solver.
// Field widths, degree codes and status codes; no dependencies.
package qrs_pkg;

    localparam int DEG_W = 2;
    localparam int CNT_W = 2;
    localparam int STAT_W = 2;
    localparam int TOL_W = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2);

    // polynomial degree codes
    localparam logic [DEG_W-1:0] DEG_CONST = 2'd0;
    localparam logic [DEG_W-1:0] DEG_LIN   = 2'd1;
    localparam logic [DEG_W-1:0] DEG_QUAD  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_LEAD = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    // root counts
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

endpackage

// ----- rtl/qrs_in_if.sv -----
// Coefficient input channel: valid/ready plus one coefficient set.
// Depends on qrs_pkg for the degree width.
interface qrs_in_if #(parameter int COEFF_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic [qrs_pkg::DEG_W-1:0]    degree;
    logic signed [COEFF_WIDTH-1:0] const_coeff;
    logic signed [COEFF_WIDTH-1:0] linear_coeff;
    logic signed [COEFF_WIDTH-1:0] square_coeff;

    modport source (output valid, degree, const_coeff, linear_coeff, square_coeff,
                    input ready);
    modport sink   (input valid, degree, const_coeff, linear_coeff, square_coeff,
                    output ready);
endinterface

// ----- rtl/qrs_out_if.sv -----
// Result output channel: valid/ready plus root count, roots and status.
// Depends on qrs_pkg for count and status widths.
interface qrs_out_if #(parameter int COEFF_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic [qrs_pkg::CNT_W-1:0]     root_count;
    logic signed [COEFF_WIDTH-1:0] root_low;
    logic signed [COEFF_WIDTH-1:0] root_high;
    logic [qrs_pkg::STAT_W-1:0]    status;

    modport source (output valid, root_count, root_low, root_high, status, input ready);
    modport sink   (input valid, root_count, root_low, root_high, status, output ready);
endinterface

// ----- rtl/qrs_cfg_if.sv -----
// Configuration write channel for the discriminant tolerance register.
// Depends on qrs_pkg for the register width.
interface qrs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [qrs_pkg::TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/quadratic_root_solver.sv -----
// Quadratic root solver top level: real roots of degree 0..2 polynomials.
// Pipeline: three front stages, one square-root cell per root bit, a numerator
// register, one divider cell per quotient bit, output register.
// Throughput one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) empties the pipeline and sets tolerance to 2.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if, qrs_cfg_if and the two cell modules.
module quadratic_root_solver #(
    parameter int COEFF_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qrs_cfg_if.sink  i_cfg,
    qrs_in_if.sink   i_item,
    qrs_out_if.source o_result
);

    localparam int W   = COEFF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;        // products
    localparam int DW  = 2 * W + 2;    // discriminant, signed
    localparam int RTW = W + 1;        // square root
    localparam int MW  = W + 3;        // square root remainder
    localparam int NW  = W + 1;        // negated coefficient
    localparam int DVW = W + 1;        // divisor
    localparam int XW  = W + F + 2;    // doubled, scaled dividend magnitude
    localparam int SMW = W + 3;        // numerator including the root

    localparam logic [XW-1:0] MAG_POS = XW'({1'b0, {(W-1){1'b1}}});
    localparam logic [XW-1:0] MAG_NEG = XW'({1'b1, {(W-1){1'b0}}});
    localparam logic [W-1:0]  VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VAL_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [qrs_pkg::CNT_W-1:0]  count;
        logic [qrs_pkg::STAT_W-1:0] status;
        logic                       use_s;
        logic signed [NW-1:0]       n0;
        logic [DVW-1:0]             den;
    } t_ctx;

    typedef struct packed {
        logic [qrs_pkg::CNT_W-1:0]  count;
        logic [qrs_pkg::STAT_W-1:0] status;
        logic                       neg_lo;
        logic                       neg_hi;
    } t_dctx;

    localparam int SQW = $bits(t_ctx);
    localparam int DCW = $bits(t_dctx);

    // rounding (half up on the doubled quotient), sign and saturation
    function automatic logic [W:0] round_sat(input logic [XW-1:0] q2, input logic neg);
        logic [XW:0]   qsum;
        logic [XW-1:0] qr;
        logic          sat;
        logic [W-1:0]  val;
        qsum = (XW+1)'(q2) + (XW+1)'(1);
        qr   = qsum[XW:1];
        sat  = neg ? (qr > MAG_NEG) : (qr > MAG_POS);
        if (sat) begin
            val = neg ? VAL_MIN : VAL_MAX;
        end else begin
            val = neg ? W'(-qr[W-1:0]) : qr[W-1:0];
        end
        return {sat, val};
    endfunction

    logic en;

    // tolerance register
    logic [qrs_pkg::TOL_W-1:0] r_tol;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    // global advance: move whenever the output slot is free or being taken
    logic r_out_valid;

    assign en           = !r_out_valid || o_result.ready;
    assign i_item.ready = en;

    // front stages: capture, multiply, discriminant
    logic                      r_v0, r_v1, r_v2;
    logic [qrs_pkg::DEG_W-1:0] r_deg0, r_deg1, r_deg2;
    logic signed [W-1:0]       r_c0, r_b0, r_a0;
    logic signed [W-1:0]       r_c1, r_b1, r_a1;
    logic signed [W-1:0]       r_c2, r_b2, r_a2;
    logic signed [PW-1:0]      r_bb1, r_ac1;
    logic signed [DW-1:0]      r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_item.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg0 <= i_item.degree;
            r_c0   <= i_item.const_coeff;
            r_b0   <= i_item.linear_coeff;
            r_a0   <= i_item.square_coeff;
            r_deg1 <= r_deg0;
            r_c1   <= r_c0;
            r_b1   <= r_b0;
            r_a1   <= r_a0;
            r_bb1  <= PW'(r_b0) * PW'(r_b0);
            r_ac1  <= PW'(r_a0) * PW'(r_c0);
            r_deg2 <= r_deg1;
            r_c2   <= r_c1;
            r_b2   <= r_b1;
            r_a2   <= r_a1;
            r_d2   <= DW'(r_bb1) - (DW'(r_ac1) <<< 2);
        end
    end

    // classify the item and set up numerator base and divisor
    logic signed [DW-1:0] tol_s;
    logic                 d_below;
    logic                 d_two;
    t_ctx                 n_ctx;
    logic [DW-1:0]        n_rad;

    always_comb begin
        tol_s   = $signed(DW'(r_tol));
        d_below = (r_d2 < -tol_s);
        d_two   = (r_d2 >= tol_s);
        n_ctx.count  = qrs_pkg::CNT_NONE;
        n_ctx.status = qrs_pkg::ST_OK;
        n_ctx.use_s  = 1'b0;
        n_ctx.n0     = '0;
        n_ctx.den    = DVW'(1);
        unique case (r_deg2)
            qrs_pkg::DEG_CONST: begin
                n_ctx.status = (r_c2 > 0) ? qrs_pkg::ST_OK : qrs_pkg::ST_LEAD;
            end
            qrs_pkg::DEG_LIN: begin
                if (r_b2 > 0) begin
                    n_ctx.count = qrs_pkg::CNT_ONE;
                    n_ctx.n0    = -(NW'(r_c2));
                    n_ctx.den   = DVW'(r_b2);
                end else begin
                    n_ctx.status = qrs_pkg::ST_LEAD;
                end
            end
            qrs_pkg::DEG_QUAD: begin
                if (r_a2 > 0) begin
                    n_ctx.den = DVW'(r_a2) << 1;
                    n_ctx.n0  = -(NW'(r_b2));
                    if (d_below) begin
                        n_ctx.count = qrs_pkg::CNT_NONE;
                    end else if (d_two) begin
                        n_ctx.count = qrs_pkg::CNT_TWO;
                        n_ctx.use_s = 1'b1;
                    end else begin
                        n_ctx.count = qrs_pkg::CNT_ONE;
                    end
                end else begin
                    n_ctx.status = qrs_pkg::ST_LEAD;
                end
            end
            default: begin
                n_ctx.status = qrs_pkg::ST_LEAD;
            end
        endcase
        n_rad = r_d2[DW-1] ? '0 : DW'(r_d2);
    end

    // square root chain
    logic           sq_v    [0:RTW];
    logic [MW-1:0]  sq_rem  [0:RTW];
    logic [RTW-1:0] sq_root [0:RTW];
    logic [DW-1:0]  sq_rad  [0:RTW];
    logic [SQW-1:0] sq_side [0:RTW];

    assign sq_v[0]    = r_v2;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = n_rad;
    assign sq_side[0] = n_ctx;

    for (genvar k = 0; k < RTW; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .RW  (DW),
            .RTW (RTW),
            .MW  (MW),
            .SW  (SQW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_rad   (sq_rad[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // form both numerators and their scaled magnitudes
    t_ctx                  sq_ctx;
    logic [RTW-1:0]        s_used;
    logic signed [SMW-1:0] num_lo, num_hi;
    logic [SMW-1:0]        mag_lo, mag_hi;
    t_dctx                 n_dctx;

    always_comb begin
        sq_ctx = t_ctx'(sq_side[RTW]);
        s_used = sq_ctx.use_s ? sq_root[RTW] : '0;
        num_lo = SMW'(sq_ctx.n0) - $signed({2'b00, s_used});
        num_hi = SMW'(sq_ctx.n0) + $signed({2'b00, s_used});
        mag_lo = num_lo[SMW-1] ? SMW'(-num_lo) : SMW'(num_lo);
        mag_hi = num_hi[SMW-1] ? SMW'(-num_hi) : SMW'(num_hi);
        n_dctx.count  = sq_ctx.count;
        n_dctx.status = sq_ctx.status;
        n_dctx.neg_lo = num_lo[SMW-1];
        n_dctx.neg_hi = num_hi[SMW-1];
    end

    logic           r_v4;
    logic [XW-1:0]  r_x_lo, r_x_hi;
    logic [DVW-1:0] r_den4;
    t_dctx          r_dctx4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= sq_v[RTW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_lo  <= {mag_lo[W:0], {(F+1){1'b0}}};
            r_x_hi  <= {mag_hi[W:0], {(F+1){1'b0}}};
            r_den4  <= sq_ctx.den;
            r_dctx4 <= n_dctx;
        end
    end

    // divider chain, both roots side by side
    logic           dv_v      [0:XW];
    logic [DVW-1:0] dv_d      [0:XW];
    logic [DVW-1:0] dv_rem_lo [0:XW];
    logic [XW-1:0]  dv_xq_lo  [0:XW];
    logic [DVW-1:0] dv_rem_hi [0:XW];
    logic [XW-1:0]  dv_xq_hi  [0:XW];
    logic [DCW-1:0] dv_side   [0:XW];

    assign dv_v[0]      = r_v4;
    assign dv_d[0]      = r_den4;
    assign dv_rem_lo[0] = '0;
    assign dv_xq_lo[0]  = r_x_lo;
    assign dv_rem_hi[0] = '0;
    assign dv_xq_hi[0]  = r_x_hi;
    assign dv_side[0]   = r_dctx4;

    for (genvar k = 0; k < XW; k++) begin : g_div
        qrs_div_cell #(
            .XW  (XW),
            .DVW (DVW),
            .SW  (DCW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (dv_v[k]),
            .i_d      (dv_d[k]),
            .i_rem_lo (dv_rem_lo[k]),
            .i_xq_lo  (dv_xq_lo[k]),
            .i_rem_hi (dv_rem_hi[k]),
            .i_xq_hi  (dv_xq_hi[k]),
            .i_side   (dv_side[k]),
            .o_valid  (dv_v[k+1]),
            .o_d      (dv_d[k+1]),
            .o_rem_lo (dv_rem_lo[k+1]),
            .o_xq_lo  (dv_xq_lo[k+1]),
            .o_rem_hi (dv_rem_hi[k+1]),
            .o_xq_hi  (dv_xq_hi[k+1]),
            .o_side   (dv_side[k+1])
        );
    end

    // round, saturate and assemble the result
    t_dctx         dv_ctx;
    logic [W:0]    rs_lo, rs_hi;
    logic          use_lo, use_hi;
    logic          sat_any;
    logic [qrs_pkg::CNT_W-1:0]  n_count;
    logic [W-1:0]               n_lo, n_hi;
    logic [qrs_pkg::STAT_W-1:0] n_status;

    always_comb begin
        dv_ctx   = t_dctx'(dv_side[XW]);
        rs_lo    = round_sat(dv_xq_lo[XW], dv_ctx.neg_lo);
        rs_hi    = round_sat(dv_xq_hi[XW], dv_ctx.neg_hi);
        use_lo   = (dv_ctx.count != qrs_pkg::CNT_NONE);
        use_hi   = (dv_ctx.count == qrs_pkg::CNT_TWO);
        sat_any  = (use_lo && rs_lo[W]) || (use_hi && rs_hi[W]);
        n_count  = dv_ctx.count;
        n_lo     = use_lo ? rs_lo[W-1:0] : '0;
        n_hi     = use_hi ? rs_hi[W-1:0] : '0;
        n_status = sat_any ? qrs_pkg::ST_SAT : dv_ctx.status;
    end

    logic [qrs_pkg::CNT_W-1:0]  r_count;
    logic [W-1:0]               r_lo, r_hi;
    logic [qrs_pkg::STAT_W-1:0] r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v[XW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_count  <= n_count;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_status <= n_status;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.root_count = r_count;
    assign o_result.root_low   = r_lo;
    assign o_result.root_high  = r_hi;
    assign o_result.status     = r_status;

endmodule

// ----- rtl/qrs_sqrt_cell.sv -----
// One stage of the digit-by-digit square root chain: one root bit per cell.
// Carries a side vector of item context alongside; no package use.
module qrs_sqrt_cell #(
    parameter int RW  = 66,
    parameter int RTW = 33,
    parameter int MW  = 35,
    parameter int SW  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [MW-1:0]  i_rem,
    input  logic [RTW-1:0] i_root,
    input  logic [RW-1:0]  i_rad,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [MW-1:0]  o_rem,
    output logic [RTW-1:0] o_root,
    output logic [RW-1:0]  o_rad,
    output logic [SW-1:0]  o_side
);

    logic [MW+1:0]  rem2;
    logic [MW+1:0]  trial;
    logic           ge;
    logic [MW-1:0]  n_rem;
    logic [RTW-1:0] n_root;
    logic [RW-1:0]  n_rad;
    logic           r_valid;
    logic [MW-1:0]  r_rem;
    logic [RTW-1:0] r_root;
    logic [RW-1:0]  r_rad;
    logic [SW-1:0]  r_side;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        rem2   = {i_rem, i_rad[RW-1 -: 2]};
        trial  = (MW+2)'({i_root, 2'b01});
        ge     = (rem2 >= trial);
        n_rem  = ge ? MW'(rem2 - trial) : MW'(rem2);
        n_root = {i_root[RTW-2:0], ge};
        n_rad  = {i_rad[RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

// ----- rtl/qrs_div_cell.sv -----
// One stage of the restoring divider chain: one quotient bit per cell for
// both root lanes, which share the divisor. No package use.
module qrs_div_cell #(
    parameter int XW  = 50,
    parameter int DVW = 33,
    parameter int SW  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [DVW-1:0] i_d,
    input  logic [DVW-1:0] i_rem_lo,
    input  logic [XW-1:0]  i_xq_lo,
    input  logic [DVW-1:0] i_rem_hi,
    input  logic [XW-1:0]  i_xq_hi,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output logic [DVW-1:0] o_d,
    output logic [DVW-1:0] o_rem_lo,
    output logic [XW-1:0]  o_xq_lo,
    output logic [DVW-1:0] o_rem_hi,
    output logic [XW-1:0]  o_xq_hi,
    output logic [SW-1:0]  o_side
);

    logic [DVW:0]   t_lo_w;
    logic [DVW:0]   t_hi_w;
    logic [DVW:0]   d_ext;
    logic           ge_lo;
    logic           ge_hi;
    logic [DVW-1:0] n_rem_lo;
    logic [DVW-1:0] n_rem_hi;
    logic [XW-1:0]  n_xq_lo;
    logic [XW-1:0]  n_xq_hi;
    logic           r_valid;
    logic [DVW-1:0] r_d;
    logic [DVW-1:0] r_rem_lo;
    logic [XW-1:0]  r_xq_lo;
    logic [DVW-1:0] r_rem_hi;
    logic [XW-1:0]  r_xq_hi;
    logic [SW-1:0]  r_side;

    // shift in the next dividend bit, subtract if it fits
    always_comb begin
        d_ext    = (DVW+1)'(i_d);
        t_lo_w   = {i_rem_lo, i_xq_lo[XW-1]};
        t_hi_w   = {i_rem_hi, i_xq_hi[XW-1]};
        ge_lo    = (t_lo_w >= d_ext);
        ge_hi    = (t_hi_w >= d_ext);
        n_rem_lo = ge_lo ? DVW'(t_lo_w - d_ext) : DVW'(t_lo_w);
        n_rem_hi = ge_hi ? DVW'(t_hi_w - d_ext) : DVW'(t_hi_w);
        n_xq_lo  = {i_xq_lo[XW-2:0], ge_lo};
        n_xq_hi  = {i_xq_hi[XW-2:0], ge_hi};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d      <= i_d;
            r_rem_lo <= n_rem_lo;
            r_xq_lo  <= n_xq_lo;
            r_rem_hi <= n_rem_hi;
            r_xq_hi  <= n_xq_hi;
            r_side   <= i_side;
        end
    end

    assign o_valid  = r_valid;
    assign o_d      = r_d;
    assign o_rem_lo = r_rem_lo;
    assign o_xq_lo  = r_xq_lo;
    assign o_rem_hi = r_rem_hi;
    assign o_xq_hi  = r_xq_hi;
    assign o_side   = r_side;

endmodule

// ----- sim/qrs_checker.sv -----
// Result checker for the quadratic root solver: watches the config, item and
// result channels, predicts each result and compares. Depends on qrs_pkg and the
// three channel interfaces.
module qrs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_cfg_if         cfg,
    qrs_in_if          item,
    qrs_out_if         result,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [qrs_pkg::CNT_W-1:0]  count;
        logic [31:0]                low;
        logic [31:0]                high;
        logic [qrs_pkg::STAT_W-1:0] status;
    } t_roots;

    localparam longint RANGE_MAX = 64'sd2147483647;
    localparam longint RANGE_MIN = -64'sd2147483648;
    localparam longint DISC_FAR  = 64'sd1 << 34;

    t_roots                    expected_roots[$];
    logic [qrs_pkg::TOL_W-1:0] tolerance;

    // floor square root of a 64-bit value, bit by bit
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // rounded division, ties away from zero, saturated to Q16.16
    function automatic longint round_div(longint num, longint den, ref bit sat);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        longint          r;
        neg = num < 0;
        mag = neg ? longint'(-(num + 1)) + 1 : num;
        q   = mag / longint'(den);
        rem = mag % longint'(den);
        if (2 * rem >= longint'(den)) q++;
        r = neg ? -longint'(q) : longint'(q);
        if (r > RANGE_MAX) begin sat = 1; return RANGE_MAX; end
        if (r < RANGE_MIN) begin sat = 1; return RANGE_MIN; end
        return r;
    endfunction

    function automatic t_roots solve_roots(logic [qrs_pkg::DEG_W-1:0] deg,
                                           logic signed [31:0] c_in,
                                           logic signed [31:0] b_in,
                                           logic signed [31:0] a_in);
        longint          c, b, a, lo, hi, q, d, tol, sr;
        longint unsigned bmag, b2, rbit, uq, t, tt, s;
        int              band;
        bit              sat;
        t_roots          r;
        c = c_in; b = b_in; a = a_in;
        lo = 0; hi = 0; sat = 0;
        r = '0;
        r.count  = qrs_pkg::CNT_NONE;
        r.status = qrs_pkg::ST_OK;
        case (deg)
            qrs_pkg::DEG_CONST: r.status = (c > 0) ? qrs_pkg::ST_OK : qrs_pkg::ST_LEAD;
            qrs_pkg::DEG_LIN: begin
                if (b > 0) begin
                    lo = round_div(-c * 65536, b, sat);
                    r.count = qrs_pkg::CNT_ONE;
                end else begin
                    r.status = qrs_pkg::ST_LEAD;
                end
            end
            qrs_pkg::DEG_QUAD: begin
                if (a > 0) begin
                    bmag = (b < 0) ? -b : b;
                    b2   = bmag * bmag;
                    rbit = b2 & 3;
                    q    = longint'(b2 >> 2) - a * c;
                    tol  = tolerance;
                    if (q <= -DISC_FAR) band = -1;
                    else if (q >= DISC_FAR) band = 1;
                    else begin
                        d = 4 * q + longint'(rbit);
                        band = (d < -tol) ? -1 : (d >= tol) ? 1 : 0;
                    end
                    if (band == 0) begin
                        lo = round_div(-b * 65536, 2 * a, sat);
                        r.count = qrs_pkg::CNT_ONE;
                    end else if (band == 1) begin
                        uq = q;
                        t  = floor_sqrt(uq);
                        tt = t * t + t;
                        s  = 2 * t;
                        if (tt < uq || (tt == uq && rbit == 1)) s = s + 1;
                        sr = s;
                        lo = round_div((-b - sr) * 65536, 2 * a, sat);
                        hi = round_div((-b + sr) * 65536, 2 * a, sat);
                        r.count = qrs_pkg::CNT_TWO;
                    end
                end else begin
                    r.status = qrs_pkg::ST_LEAD;
                end
            end
            default: r.status = qrs_pkg::ST_LEAD;
        endcase
        if (sat) r.status = qrs_pkg::ST_SAT;
        r.low  = lo[31:0];
        r.high = hi[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    assign o_pending = expected_roots.size();

    // track config, predict on item transfer, compare on result transfer
    always @(posedge i_clk) begin
        t_roots got;
        t_roots want;
        if (!i_rst_n) begin
            tolerance      = qrs_pkg::TOL_RESET;
            o_fail_count   = 0;
            o_results_seen = 0;
        end else begin
            if (cfg.valid && cfg.ready) tolerance = cfg.data;
            if (item.valid && item.ready)
                expected_roots.push_back(solve_roots(item.degree, item.const_coeff,
                                                     item.linear_coeff, item.square_coeff));
            if (result.valid && result.ready) begin
                o_results_seen++;
                got = {result.root_count, result.root_low, result.root_high, result.status};
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_roots.pop_front();
                    if (got.count !== want.count)
                        report_mismatch("root_count", got.count, want.count);
                    if (got.low !== want.low)
                        report_mismatch("root_low", $signed(got.low), $signed(want.low));
                    if (got.high !== want.high)
                        report_mismatch("root_high", $signed(got.high), $signed(want.high));
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
        end
    end
endmodule

// ----- sim/tb_quadratic_root_solver.sv -----
// Testbench top for the quadratic root solver: clock, reset, coefficient and
// tolerance stimulus, random back-pressure, verdict. Depends on qrs_pkg, the
// channel interfaces, qrs_checker and the solver RTL.
module tb_quadratic_root_solver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 88;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, results_seen, idle_cycles, items_sent;

    qrs_cfg_if cfg_ch();
    qrs_in_if  item_ch();
    qrs_out_if result_ch();

    quadratic_root_solver i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    qrs_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .cfg            (cfg_ch),
        .item           (item_ch),
        .result         (result_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // mostly short gaps, occasionally long
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    bit stall_on;
    initial begin
        int g;
        result_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            result_ch.ready <= 1'b1;
            if (stall_on) begin
                g = gap_len();
                @(posedge i_clk);
                if (g > 0) begin
                    result_ch.ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end else begin
                @(posedge i_clk);
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("quadratic_root_solver regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic [qrs_pkg::DEG_W-1:0] deg, logic [31:0] c,
                             logic [31:0] b, logic [31:0] a);
        int g;
        item_ch.valid        <= 1'b1;
        item_ch.degree       <= deg;
        item_ch.const_coeff  <= c;
        item_ch.linear_coeff <= b;
        item_ch.square_coeff <= a;
        @(posedge i_clk iff item_ch.ready);
        items_sent++;
        g = gap_len();
        if (g > 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [qrs_pkg::TOL_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk iff cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 2) << 16 | $urandom_range(0, 65535);
            2: return -($urandom_range(1, 5) << 16);
            3: return $urandom_range(1, 8) << 16;
            4: return $urandom_range(0, 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // a quadratic with chosen integer-ish roots and a positive leading term
    task automatic send_roots_form();
        longint a, r1, r2, b, c;
        a  = $urandom_range(1, 4) << 14;
        r1 = $signed($urandom_range(0, 16)) - 8;
        r2 = $urandom_range(0, 3) == 0 ? r1 : $signed($urandom_range(0, 16)) - 8;
        b  = -a * (r1 + r2);
        c  = a * r1 * r2;
        send_item(qrs_pkg::DEG_QUAD, c[31:0], b[31:0], a[31:0]);
    endtask

    task automatic random_phase(int n);
        logic [qrs_pkg::DEG_W-1:0] deg;
        logic [31:0] a;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_roots_form();
                3:       send_item(qrs_pkg::DEG_CONST, rand_word(), rand_word(), rand_word());
                4, 5:    send_item(qrs_pkg::DEG_LIN, rand_word(), rand_word(), rand_word());
                6:       send_item(qrs_pkg::DEG_W'($urandom_range(0, 3)), $urandom, $urandom,
                                   $urandom);
                default: begin
                    a = $urandom_range(0, 7) == 0 ? rand_word() :
                        ($urandom | 32'h1) & 32'h7FFFFFFF;
                    send_item(qrs_pkg::DEG_QUAD, rand_word(), rand_word(), a);
                end
            endcase
        end
    endtask

    initial begin
        logic [qrs_pkg::TOL_W-1:0] tol_set [4];
        i_rst_n       = 1'b0;
        stall_on      = 1'b0;
        items_sent    = 0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        item_ch.valid = 1'b0;
        item_ch.degree = qrs_pkg::DEG_CONST;
        item_ch.const_coeff  = '0;
        item_ch.linear_coeff = '0;
        item_ch.square_coeff = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset tolerance, each degree, bad leading term, saturation
        send_item(qrs_pkg::DEG_CONST, 32'h0001_0000, 0, 0);
        send_item(qrs_pkg::DEG_CONST, 0, 0, 0);
        send_item(qrs_pkg::DEG_CONST, 32'h8000_0000, 0, 0);
        send_item(qrs_pkg::DEG_CONST, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(qrs_pkg::DEG_LIN, 32'h0002_0000, 32'h0001_0000, 0);
        send_item(qrs_pkg::DEG_LIN, 32'h0001_0000, 0, 0);
        send_item(qrs_pkg::DEG_LIN, 0, 32'h8000_0000, 0);
        send_item(qrs_pkg::DEG_LIN, 32'h7FFF_FFFF, 32'h0000_0001, 0);
        send_item(qrs_pkg::DEG_LIN, 32'h8000_0000, 32'h0000_0001, 0);
        send_item(qrs_pkg::DEG_LIN, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(qrs_pkg::DEG_QUAD, 32'hFFFF_0000, 0, 32'h0001_0000);
        send_item(qrs_pkg::DEG_QUAD, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        send_item(qrs_pkg::DEG_QUAD, 32'h0001_0000, 0, 32'h0001_0000);
        send_item(qrs_pkg::DEG_QUAD, 32'h0001_0000, 0, 0);
        send_item(qrs_pkg::DEG_QUAD, 0, 0, 32'h8000_0000);
        send_item(qrs_pkg::DEG_QUAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(qrs_pkg::DEG_QUAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(qrs_pkg::DEG_QUAD, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(qrs_pkg::DEG_QUAD, 0, 32'h0000_0001, 32'h0000_0001);
        send_item(2'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // tolerance settings: zero, max, moderate, random
        tol_set[0] = '0;
        tol_set[1] = 32'hFFFF_FFFF;
        tol_set[2] = 32'h0000_1000;
        tol_set[3] = $urandom;
        stall_on = 1'b1;
        for (int k = 0; k < 4; k++) begin
            write_tolerance(tol_set[k]);
            send_item(qrs_pkg::DEG_QUAD, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
            send_item(qrs_pkg::DEG_QUAD, 32'h0000_4000, 32'h0001_0000, 32'h0001_0000);
            send_item(qrs_pkg::DEG_QUAD, 32'h0000_0001, 32'h0000_0003, 32'h0000_0001);
            random_phase(140);
            drain();
        end
        write_tolerance(qrs_pkg::TOL_RESET);
        random_phase(40);
        drain();

        $display("covered %0d items over %0d results, five tolerance settings,", items_sent,
                 results_seen);
        $display("all degrees incl. unsupported, saturation and back-pressure");
        if (fail_count == 0)
            $display("quadratic_root_solver regression: pass");
        else
            $display("quadratic_root_solver regression: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/qrs_pkg.sv
rtl/qrs_in_if.sv
rtl/qrs_out_if.sv
rtl/qrs_cfg_if.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
sim/qrs_checker.sv
sim/tb_quadratic_root_solver.sv
